/* src/png_scanline_to_rgba_unpack_core_defines.svh */
// Assertion macros shared by the checker of the scanline unpacker.
`ifndef PNG_SCANLINE_TO_RGBA_UNPACK_CORE_DEFINES_SVH
`define PNG_SCANLINE_TO_RGBA_UNPACK_CORE_DEFINES_SVH

// Checked at every clock edge, reset included.
`define PNGU_ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);

// Checked only while reset is released.
`define PNGU_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

`endif

/* src/pngu_pkg.sv */
// Types, constants and helper functions of the scanline unpacker.
`default_nettype none
package pngu_pkg;

	localparam logic ACT_DATA = 1'b0;
	localparam logic ACT_TABLE = 1'b1;

	localparam logic [2:0] CT_INDEXED = 3'd3;

	localparam logic [1:0] CFG_PIX_FORMAT = 2'd0;
	localparam logic [1:0] CFG_CHAN_BITS = 2'd1;
	localparam logic [1:0] CFG_PIX_BYTES = 2'd2;
	localparam logic [1:0] CFG_IMAGE_WIDTH = 2'd3;

	localparam logic [16:0] MAX_WIDTH = 17'd4096;

	localparam int OBUF_DEPTH = 4;
	localparam int OBUF_AW = 2;

	typedef struct packed {
		logic [2:0] pix_format;
		logic [4:0] chan_bits;
		logic [3:0] pix_bytes;
		logic [12:0] image_width;
	} cfg_regs_t;

	typedef struct packed {
		logic rd_en;
		logic [7:0] rd_addr;
		logic wr_en;
		logic [7:0] wr_addr;
		logic [31:0] wr_data;
	} mem_req_t;

	typedef struct packed {
		logic valid;
		logic [11:0] col;
		logic from_mem;
		logic zero;
		logic [31:0] direct;
		logic last;
	} issue_t;

	typedef struct packed {
		logic [11:0] pixel_column;
		logic [31:0] rgba_pixel;
		logic last_of_byte;
	} out_item_t;

	function automatic logic [2:0] col_offset(input logic [2:0] pass);
		logic [2:0] r;
		unique case (pass)
			3'd1: r = 3'd4;
			3'd3: r = 3'd2;
			3'd5: r = 3'd1;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] col_shift(input logic [2:0] pass);
		logic [1:0] r;
		unique case (pass)
			3'd0, 3'd1: r = 2'd3;
			3'd2, 3'd3: r = 2'd2;
			3'd4, 3'd5: r = 2'd1;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [3:0] pos,
			input logic [7:0] v);
		logic [31:0] r;
		r = word;
		unique case (pos)
			4'd0: r[31:24] = v;
			4'd1: r[23:16] = v;
			4'd2: r[15:8] = v;
			4'd3: r[7:0] = v;
			default: r = word;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] grey_pos(input logic [3:0] kept, input logic grey);
		return kept + ((grey && kept != 4'd0) ? 4'd2 : 4'd0);
	endfunction

endpackage
`default_nettype wire

/* src/pngu_ifs.sv */
// Handshake interfaces for scanline input, pixel output and configuration writes.
`default_nettype none
interface pngu_scan_if;
	logic valid;
	logic ready;
	logic action;
	logic [7:0] data_byte;
	logic [2:0] pass_number;
	logic last_in_row;
	logic [7:0] table_index;
	logic [31:0] table_value;

	modport source(output valid, action, data_byte, pass_number, last_in_row, table_index,
		table_value, input ready);
	modport sink(input valid, action, data_byte, pass_number, last_in_row, table_index,
		table_value, output ready);
endinterface

interface pngu_pix_if;
	logic valid;
	logic ready;
	logic [11:0] pixel_column;
	logic [31:0] rgba_pixel;
	logic last_of_byte;

	modport source(output valid, pixel_column, rgba_pixel, last_of_byte, input ready);
	modport sink(input valid, pixel_column, rgba_pixel, last_of_byte, output ready);
endinterface

interface pngu_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [12:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/png_scanline_to_rgba_unpack_core.sv */
// Top level of the PNG scanline to RGBA unpacker.
// Channels: scanline takes one item per cycle while the block is ready, either an
// unfiltered scanline byte with its Adam7 pass and row-end flag, or a palette table write.
// pixels delivers RGBA pixels with their row column and a flag on the last pixel that a
// byte caused. cfg writes the color type, bit depth, bytes per pixel and image width; it
// is always ready. The user must write it only while the block is idle; the block itself
// does not enforce this. A pixel passes from the item register through the read-data
// alignment stage and the output queue to pixels. At depths of 8 and 16 one byte is taken
// every cycle while the output queue has room. Below 8 bits, and for indexed images, each
// byte yields up to 8/depth pixels, one per cycle while the queue has room, each a read
// of the palette memory; a byte is held until its last pixel. Table writes emit none.
// Reset clears the row position, the partial pixel and the output queue; the palette
// contents are undefined until written. When the receiver stalls, up to four pixels queue
// up before the sequencer pauses and scanline ready drops.
`default_nettype none
module png_scanline_to_rgba_unpack_core #(
	parameter int TABLE_DEPTH = 256
) (
	input logic clk,
	input logic arst_n,
	pngu_scan_if.sink scanline,
	pngu_pix_if.source pixels,
	pngu_cfg_if.sink cfg
);
	import pngu_pkg::*;

	cfg_regs_t cfg_q;
	mem_req_t mem_req;
	issue_t issue;
	logic [31:0] rd_data;
	logic issue_ok;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pix_format <= 3'd6;
			cfg_q.chan_bits <= 5'd8;
			cfg_q.pix_bytes <= 4'd4;
			cfg_q.image_width <= 13'd4096;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_PIX_FORMAT: cfg_q.pix_format <= cfg.data[2:0];
				CFG_CHAN_BITS: cfg_q.chan_bits <= cfg.data[4:0];
				CFG_PIX_BYTES: cfg_q.pix_bytes <= cfg.data[3:0];
				CFG_IMAGE_WIDTH: cfg_q.image_width <= cfg.data;
			endcase
		end
	end

	pngu_unpack_seq #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_regs(cfg_q),
		.scanline(scanline),
		.issue_ok(issue_ok),
		.mem_req(mem_req),
		.issue(issue)
	);

	pngu_palette_mem #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_mem (
		.clk(clk),
		.mem_req(mem_req),
		.rd_data(rd_data)
	);

	pngu_out_buf u_obuf (
		.clk(clk),
		.arst_n(arst_n),
		.issue(issue),
		.rd_data(rd_data),
		.issue_ok(issue_ok),
		.pixels(pixels)
	);
endmodule
`default_nettype wire

/* src/pngu_palette_mem.sv */
// Palette table: single-port-write, registered-read RGBA memory.
`default_nettype none
module pngu_palette_mem #(
	parameter int TABLE_DEPTH = 256
) (
	input logic clk,
	input pngu_pkg::mem_req_t mem_req,
	output logic [31:0] rd_data
);
	import pngu_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	logic [31:0] mem [TABLE_DEPTH];
	logic [31:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (mem_req.wr_en) begin
			mem[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_data;
		end
		if (mem_req.rd_en) begin
			rd_data_q <= mem[mem_req.rd_addr[AW-1:0]];
		end
	end

	assign rd_data = rd_data_q;
endmodule
`default_nettype wire

/* src/pngu_unpack_seq.sv */
// Item register, row state and per-pixel issue sequencer of the unpacker.
`default_nettype none
module pngu_unpack_seq #(
	parameter int TABLE_DEPTH = 256
) (
	input logic clk,
	input logic arst_n,
	input pngu_pkg::cfg_regs_t cfg_regs,
	pngu_scan_if.sink scanline,
	input logic issue_ok,
	output pngu_pkg::mem_req_t mem_req,
	output pngu_pkg::issue_t issue
);
	import pngu_pkg::*;

	logic cur_valid_q;
	logic action_q;
	logic [7:0] byte_q;
	logic [2:0] pass_q;
	logic last_q;
	logic [7:0] tidx_q;
	logic [31:0] tval_q;
	logic [2:0] bitpos_q;
	logic [12:0] next_column_q;
	logic [2:0] byte_in_pixel_q;
	logic [31:0] partial_pixel_q;

	logic accept;
	logic is_table;
	logic whole;
	logic [2:0] pass_off;
	logic [1:0] pass_sh;
	logic [16:0] col;
	logic [16:0] col_next;
	logic [16:0] width_eff;
	logic col_in;
	logic col_next_in;
	logic grey;
	logic d8;
	logic [3:0] bpp;
	logic [3:0] b_inc;
	logic [3:0] kept;
	logic [3:0] kept_inc;
	logic keep;
	logic full;
	logic [31:0] word;
	logic [1:0] dlog;
	logic [3:0] dstep;
	logic [7:0] shifted;
	logic [7:0] pal_idx;
	logic final_slot;
	logic emit;
	logic cur_done;
	logic issue_fire;

	always_comb begin
		is_table = action_q == ACT_TABLE;
		whole = cfg_regs.pix_format != CT_INDEXED && cfg_regs.chan_bits >= 5'd8;

		pass_off = col_offset(pass_q);
		pass_sh = col_shift(pass_q);
		col = 17'(pass_off) + (17'(next_column_q) << pass_sh);
		col_next = 17'(pass_off) + ((17'(next_column_q) + 17'd1) << pass_sh);
		width_eff = (17'(cfg_regs.image_width) < MAX_WIDTH) ? 17'(cfg_regs.image_width)
			: MAX_WIDTH;
		col_in = col < width_eff;
		col_next_in = col_next < width_eff;

		grey = !cfg_regs.pix_format[1];
		d8 = cfg_regs.chan_bits == 5'd8;
		priority if (cfg_regs.pix_bytes == 4'd0) begin
			bpp = 4'd1;
		end else if (cfg_regs.pix_bytes > 4'd8) begin
			bpp = 4'd8;
		end else begin
			bpp = cfg_regs.pix_bytes;
		end
		b_inc = {1'b0, byte_in_pixel_q} + 4'd1;
		kept = d8 ? {1'b0, byte_in_pixel_q} : {1'b0, b_inc[3:1]};
		keep = d8 || !byte_in_pixel_q[0];
		kept_inc = kept + {3'b000, keep};
		full = b_inc >= bpp;
		word = partial_pixel_q;
		if (keep) begin
			word = put_byte(word, grey_pos(kept, grey), byte_q);
			if (grey && kept == 4'd0) begin
				word = put_byte(word, 4'd1, byte_q);
				word = put_byte(word, 4'd2, byte_q);
			end
		end
		if (full && !cfg_regs.pix_format[2]) begin
			word = put_byte(word, grey_pos(kept_inc, grey), 8'hff);
		end

		priority if (cfg_regs.chan_bits >= 5'd8) begin
			dlog = 2'd3;
		end else if (cfg_regs.chan_bits >= 5'd4) begin
			dlog = 2'd2;
		end else if (cfg_regs.chan_bits >= 5'd2) begin
			dlog = 2'd1;
		end else begin
			dlog = 2'd0;
		end
		dstep = 4'd1 << dlog;
		shifted = byte_q << bitpos_q;
		final_slot = ({1'b0, bitpos_q} + dstep) >= 4'd8;
		unique case (dlog)
			2'd0: pal_idx = {7'd0, shifted[7]};
			2'd1: pal_idx = {6'd0, shifted[7:6]};
			2'd2: pal_idx = {4'd0, shifted[7:4]};
			default: pal_idx = shifted;
		endcase

		priority if (is_table) begin
			emit = 1'b0;
			cur_done = 1'b1;
		end else if (whole) begin
			emit = full && col_in;
			cur_done = !emit || issue_ok;
		end else begin
			emit = col_in;
			cur_done = !col_in || (issue_ok && (final_slot || !col_next_in));
		end
		issue_fire = cur_valid_q && emit && issue_ok;
	end

	assign scanline.ready = !cur_valid_q || cur_done;
	assign accept = scanline.valid && scanline.ready;

	assign issue.valid = issue_fire;
	assign issue.col = col[11:0];
	assign issue.from_mem = !whole;
	assign issue.zero = 32'(pal_idx) >= 32'(TABLE_DEPTH);
	assign issue.direct = word;
	assign issue.last = whole || final_slot || !col_next_in;

	assign mem_req.rd_en = issue_fire && !whole;
	assign mem_req.rd_addr = pal_idx;
	assign mem_req.wr_en = cur_valid_q && is_table && (32'(tidx_q) < 32'(TABLE_DEPTH));
	assign mem_req.wr_addr = tidx_q;
	assign mem_req.wr_data = tval_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= scanline.action;
			byte_q <= scanline.data_byte;
			pass_q <= scanline.pass_number;
			last_q <= scanline.last_in_row;
			tidx_q <= scanline.table_index;
			tval_q <= scanline.table_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			bitpos_q <= 3'd0;
			next_column_q <= 13'd0;
			byte_in_pixel_q <= 3'd0;
			partial_pixel_q <= 32'd0;
		end else begin
			if (accept) begin
				cur_valid_q <= 1'b1;
			end else if (cur_valid_q && cur_done) begin
				cur_valid_q <= 1'b0;
			end

			if (cur_valid_q && !is_table && !whole) begin
				if (cur_done) begin
					bitpos_q <= 3'd0;
				end else if (issue_fire) begin
					bitpos_q <= bitpos_q + dstep[2:0];
				end
			end

			if (cur_valid_q && !is_table) begin
				if (cur_done && last_q) begin
					next_column_q <= 13'd0;
					byte_in_pixel_q <= 3'd0;
					partial_pixel_q <= 32'd0;
				end else begin
					if (issue_fire && next_column_q != 13'h1fff) begin
						next_column_q <= next_column_q + 13'd1;
					end
					if (whole && cur_done) begin
						if (full) begin
							byte_in_pixel_q <= 3'd0;
							partial_pixel_q <= 32'd0;
						end else begin
							byte_in_pixel_q <= b_inc[2:0];
							partial_pixel_q <= word;
						end
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

/* src/pngu_out_buf.sv */
// Read-data alignment stage and output queue of the unpacker.
`default_nettype none
module pngu_out_buf (
	input logic clk,
	input logic arst_n,
	input pngu_pkg::issue_t issue,
	input logic [31:0] rd_data,
	output logic issue_ok,
	pngu_pix_if.source pixels
);
	import pngu_pkg::*;

	logic valid_s1;
	logic [11:0] col_s1;
	logic from_mem_s1;
	logic zero_s1;
	logic [31:0] direct_s1;
	logic last_s1;

	out_item_t fifo_q [OBUF_DEPTH];
	logic [OBUF_AW-1:0] wptr_q;
	logic [OBUF_AW-1:0] rptr_q;
	logic [OBUF_AW:0] count_q;

	out_item_t push_item;
	logic pop;

	always_comb begin
		push_item.pixel_column = col_s1;
		push_item.rgba_pixel = from_mem_s1 ? (zero_s1 ? 32'd0 : rd_data) : direct_s1;
		push_item.last_of_byte = last_s1;
	end

	assign issue_ok = (count_q + (OBUF_AW + 1)'(valid_s1)) < (OBUF_AW + 1)'(OBUF_DEPTH);
	assign pop = pixels.valid && pixels.ready;

	assign pixels.valid = count_q != '0;
	assign pixels.pixel_column = fifo_q[rptr_q].pixel_column;
	assign pixels.rgba_pixel = fifo_q[rptr_q].rgba_pixel;
	assign pixels.last_of_byte = fifo_q[rptr_q].last_of_byte;

	always_ff @(posedge clk) begin
		col_s1 <= issue.col;
		from_mem_s1 <= issue.from_mem;
		zero_s1 <= issue.zero;
		direct_s1 <= issue.direct;
		last_s1 <= issue.last;
		if (valid_s1) begin
			fifo_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			valid_s1 <= issue.valid;
			if (valid_s1) begin
				wptr_q <= wptr_q + OBUF_AW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + OBUF_AW'(1);
			end
			unique case ({valid_s1, pop})
				2'b10: count_q <= count_q + (OBUF_AW + 1)'(1);
				2'b01: count_q <= count_q - (OBUF_AW + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end
endmodule
`default_nettype wire

/* src/pngu_checker.sv */
// Port-level checker of the scanline unpacker and its bind to the top level.
`default_nettype none
`include "png_scanline_to_rgba_unpack_core_defines.svh"
module pngu_checker (
	input logic clk,
	input logic arst_n,
	input logic scan_ready,
	input logic pix_valid,
	input logic pix_ready,
	input logic [11:0] pix_column,
	input logic [31:0] pix_rgba,
	input logic pix_last,
	input logic cfg_ready
);
	`PNGU_ASSERT_ALWAYS(a_cfg_ready, clk, cfg_ready, "Configuration port is not ready.")
	`PNGU_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n && $past(!arst_n) |-> !pix_valid,
		"Pixel shown during reset.")
	`PNGU_ASSERT_ALWAYS(a_ready_after_rst, clk, $rose(arst_n) |-> scan_ready,
		"Scanline input not ready after reset.")
	`PNGU_ASSERT(a_pix_hold, clk, arst_n, pix_valid && !pix_ready |=> pix_valid &&
		$stable(pix_column) && $stable(pix_rgba) && $stable(pix_last),
		"Stalled pixel changed.")
endmodule

bind png_scanline_to_rgba_unpack_core pngu_checker u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.scan_ready(scanline.ready),
	.pix_valid(pixels.valid),
	.pix_ready(pixels.ready),
	.pix_column(pixels.pixel_column),
	.pix_rgba(pixels.rgba_pixel),
	.pix_last(pixels.last_of_byte),
	.cfg_ready(cfg.ready)
);
`default_nettype wire
